FILE: rtl/pcsa_pkg.sv
// Shared constants, codes and control types of the per-core slot allocator.
package pcsa_pkg;

   localparam int MAX_CORES_DEF = 8;
   localparam int MAX_POOLS_DEF = 16;

   localparam int REQ_W      = 1;
   localparam int CORE_W     = 3;
   localparam int SLOT_W     = 4;
   localparam int STATUS_W   = 2;
   localparam int CCFG_W     = 4;
   localparam int PCFG_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_CORES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOLS = 2'd1;

   localparam logic [CCFG_W-1:0] CORES_RESET = 4'd8;
   localparam logic [PCFG_W-1:0] POOLS_RESET = 5'd16;

   localparam logic [REQ_W-1:0] REQ_ALLOC = 1'b0;
   localparam logic [REQ_W-1:0] REQ_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_CORE  = 2'd3;

   typedef struct packed {
      logic capture;
      logic check;
      logic load_row;
      logic free_eval;
      logic mod_step;
      logic scan_step;
      logic finish;
   } pcsa_cmd_type;

   typedef struct packed {
      logic core_bad;
      logic is_free;
      logic start_ge_np;
      logic scan_hit;
      logic scan_last;
   } pcsa_stat_type;

endpackage

FILE: rtl/pcsa_channels.sv
// Handshake channel interfaces: request, response and register write.
interface pcsa_req_if;
   import pcsa_pkg::*;
   logic                valid;
   logic                ready;
   logic [REQ_W-1:0]    req_type;
   logic [CORE_W-1:0]   core_id;
   logic [SLOT_W-1:0]   slot_index;
   modport source (output valid, output req_type, output core_id, output slot_index,
                   input ready);
   modport sink   (input valid, input req_type, input core_id, input slot_index,
                   output ready);
endinterface

interface pcsa_rsp_if;
   import pcsa_pkg::*;
   logic                valid;
   logic                ready;
   logic [SLOT_W-1:0]   granted_slot;
   logic [STATUS_W-1:0] status;
   modport source (output valid, output granted_slot, output status, input ready);
   modport sink   (input valid, input granted_slot, input status, output ready);
endinterface

interface pcsa_csr_if;
   import pcsa_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/per_core_slot_allocator.sv
// Steps: check, then finish for a core out of range; else row load, then free evaluation
//   (free) or k start-index reduction steps and a scan of n (1..pools_in_use) slots, one
//   per cycle (allocate), then finish; k is nonzero only after pools shrinks.
// Throughput: one word at a time; the next request word is taken in the cycle after the
//   response word is registered, while that response may still wait for rsp ready.
// Reset: synchronous, clears all in-use flags (per-core row valid bits), start index 0.
module per_core_slot_allocator #(
   parameter int MAX_CORES = pcsa_pkg::MAX_CORES_DEF,
   parameter int MAX_POOLS = pcsa_pkg::MAX_POOLS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   pcsa_req_if.sink    req_port,
   pcsa_rsp_if.source  rsp_port,
   pcsa_csr_if.sink    csr_port
);
   import pcsa_pkg::*;

   pcsa_cmd_type  cmd;
   pcsa_stat_type stat;

   // all register writes taken; user must ensure software writes them only while idle
   assign csr_port.ready = 1'b1;

   // sequencer: accepts a request word, walks the flag row, hands off the response word
   pcsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: one flag row per core in a RAM, scanned slot by slot from the
   // shared rotating start index
   pcsa_dpath #(
      .MAX_CORES (MAX_CORES),
      .MAX_POOLS (MAX_POOLS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_port.valid && csr_port.ready),
      .csr_index    (csr_port.index),
      .csr_data     (csr_port.data),
      .req_type     (req_port.req_type),
      .core_id      (req_port.core_id),
      .slot_index   (req_port.slot_index),
      .cmd          (cmd),
      .stat         (stat),
      .granted_slot (rsp_port.granted_slot),
      .status       (rsp_port.status)
   );

endmodule

FILE: rtl/pcsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pcsa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/pcsa_ctrl.sv
// Request sequencer of the slot allocator and the response valid flag.
module pcsa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  pcsa_pkg::pcsa_stat_type stat,
   output pcsa_pkg::pcsa_cmd_type  cmd
);
   import pcsa_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_LOAD   = 3'd2;
   localparam logic [2:0] S_FREE   = 3'd3;
   localparam logic [2:0] S_MOD    = 3'd4;
   localparam logic [2:0] S_SCAN   = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.core_bad ? S_FINISH : S_LOAD;
         end
         S_LOAD: begin
            cmd.load_row = 1'b1;
            state_in     = stat.is_free ? S_FREE : S_MOD;
         end
         S_FREE: begin
            cmd.free_eval = 1'b1;
            state_in      = S_FINISH;
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (!stat.start_ge_np) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_hit || stat.scan_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/pcsa_dpath.sv
// Datapath of the slot allocator: registers, flag rows, scan and result words.
module pcsa_dpath #(
   parameter int MAX_CORES = pcsa_pkg::MAX_CORES_DEF,
   parameter int MAX_POOLS = pcsa_pkg::MAX_POOLS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [pcsa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pcsa_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic [pcsa_pkg::REQ_W-1:0]          req_type,
   input  logic [pcsa_pkg::CORE_W-1:0]         core_id,
   input  logic [pcsa_pkg::SLOT_W-1:0]         slot_index,
   input  pcsa_pkg::pcsa_cmd_type              cmd,
   output pcsa_pkg::pcsa_stat_type             stat,
   output logic [pcsa_pkg::SLOT_W-1:0]         granted_slot,
   output logic [pcsa_pkg::STATUS_W-1:0]       status
);
   import pcsa_pkg::*;

   localparam int AW     = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
   localparam int SW     = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
   localparam int CCNT_W = $clog2(MAX_CORES + 1);
   localparam int PCNT_W = $clog2(MAX_POOLS + 1);

   // configuration and persistent state
   logic [CCFG_W-1:0]    cores_cfg_ff;
   logic [PCFG_W-1:0]    pools_cfg_ff;
   logic [SW-1:0]        start_ff;
   logic [MAX_CORES-1:0] row_valid_ff;

   // per-request working registers
   logic [REQ_W-1:0]     req_type_ff;
   logic [CORE_W-1:0]    core_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [MAX_POOLS-1:0] row_ff;
   logic [SW-1:0]        cur_ff;
   logic [PCNT_W-1:0]    cnt_ff;
   logic [SW-1:0]        res_slot_ff;
   logic [STATUS_W-1:0]  res_status_ff;
   logic                 res_wr_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;

   logic [CCNT_W-1:0]    nc;
   logic [PCNT_W-1:0]    np;
   logic [AW-1:0]        addr;
   logic [SW-1:0]        cur_inc;
   logic [SW-1:0]        start_inc;
   logic [SW-1:0]        free_idx;
   logic [MAX_POOLS-1:0] rd_row;
   logic                 free_ok;

   // clamp the counts to their legal ranges
   always_comb begin
      if (cores_cfg_ff == '0) begin
         nc = CCNT_W'(1);
      end else if (32'(cores_cfg_ff) > MAX_CORES) begin
         nc = CCNT_W'(MAX_CORES);
      end else begin
         nc = CCNT_W'(cores_cfg_ff);
      end
      if (pools_cfg_ff == '0) begin
         np = PCNT_W'(1);
      end else if (32'(pools_cfg_ff) > MAX_POOLS) begin
         np = PCNT_W'(MAX_POOLS);
      end else begin
         np = PCNT_W'(pools_cfg_ff);
      end
   end

   assign addr      = AW'(core_ff);
   assign cur_inc   = (32'(cur_ff) + 1 == 32'(np)) ? '0 : SW'(32'(cur_ff) + 1);
   assign start_inc = (32'(start_ff) + 1 == 32'(np)) ? '0 : SW'(32'(start_ff) + 1);
   assign free_idx  = SW'(slot_ff);
   assign free_ok   = (32'(slot_ff) < 32'(np)) && row_ff[free_idx];

   assign stat.core_bad    = 32'(core_ff) >= 32'(nc);
   assign stat.is_free     = (req_type_ff == REQ_FREE);
   assign stat.start_ge_np = 32'(start_ff) >= 32'(np);
   assign stat.scan_hit    = !row_ff[cur_ff];
   assign stat.scan_last   = (32'(cnt_ff) + 1 == 32'(np));

   pcsa_ram #(
      .WIDTH (MAX_POOLS),
      .DEPTH (MAX_CORES)
   ) u_flags (
      .clock   (clock),
      .wr_en   (cmd.finish && res_wr_ff),
      .wr_addr (addr),
      .wr_data (row_ff),
      .rd_en   (cmd.check),
      .rd_addr (addr),
      .rd_data (rd_row)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cores_cfg_ff <= CORES_RESET;
         pools_cfg_ff <= POOLS_RESET;
         start_ff     <= '0;
         row_valid_ff <= '0;
      end else begin
         if (csr_write && csr_index == CSR_CORES) begin
            cores_cfg_ff <= csr_data[CCFG_W-1:0];
         end
         if (csr_write && csr_index == CSR_POOLS) begin
            pools_cfg_ff <= csr_data[PCFG_W-1:0];
         end
         if (cmd.mod_step) begin
            if (stat.start_ge_np) begin
               start_ff <= SW'(32'(start_ff) - 32'(np));
            end else begin
               start_ff <= start_inc;
            end
         end
         if (cmd.finish && res_wr_ff) begin
            row_valid_ff[addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff <= req_type;
         core_ff     <= core_id;
         slot_ff     <= slot_index;
      end
      if (cmd.check) begin
         res_slot_ff   <= '0;
         res_status_ff <= ST_BAD_CORE;
         res_wr_ff     <= 1'b0;
      end
      if (cmd.load_row) begin
         row_ff <= row_valid_ff[addr] ? rd_row : '0;
      end
      if (cmd.free_eval) begin
         if (free_ok) begin
            row_ff[free_idx] <= 1'b0;
            res_slot_ff      <= free_idx;
            res_status_ff    <= ST_OK;
            res_wr_ff        <= 1'b1;
         end else begin
            res_status_ff <= ST_NOT_ALLOC;
         end
      end
      if (cmd.mod_step && !stat.start_ge_np) begin
         cur_ff <= start_ff;
         cnt_ff <= '0;
      end
      if (cmd.scan_step) begin
         if (stat.scan_hit) begin
            row_ff[cur_ff] <= 1'b1;
            res_slot_ff    <= cur_ff;
            res_status_ff  <= ST_OK;
            res_wr_ff      <= 1'b1;
         end else if (stat.scan_last) begin
            res_status_ff <= ST_NO_FREE;
         end else begin
            cur_ff <= cur_inc;
            cnt_ff <= PCNT_W'(32'(cnt_ff) + 1);
         end
      end
      if (cmd.finish) begin
         rsp_slot_ff   <= SLOT_W'(res_slot_ff);
         rsp_status_ff <= res_status_ff;
      end
   end

   assign granted_slot = rsp_slot_ff;
   assign status       = rsp_status_ff;

endmodule
